@@ design/dfsm_pkg.sv @@
package dfsm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned SUM_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_INC_EN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INC_VAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SND_EN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SND_VAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_BYTES  = 3'd4;

    localparam logic [7:0] HDR_BYTES_RESET = 8'd40;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_INC_MISS  = 3'd2,
        VERDICT_SND_MISS  = 3'd3,
        VERDICT_MALFORMED = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        SEQ_NOT_CHECKED  = 3'd0,
        SEQ_FIRST_SEEN   = 3'd1,
        SEQ_IN_ORDER     = 3'd2,
        SEQ_MISSING      = 3'd3,
        SEQ_OUT_OF_ORDER = 3'd4,
        SEQ_TABLE_FULL   = 3'd5
    } t_seq_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_CMP,
        ST_HIT,
        ST_MISS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic check;
        logic rd;
        logic next_idx;
        logic hit;
        logic miss;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic pass;
        logic tbl_empty;
        logic match;
        logic last;
        logic out_space;
    } t_dp_sts;

endpackage

@@ design/dfsm_if.sv @@
interface dfsm_hdr_if;
    logic               valid;
    logic               ready;
    logic        [15:0] datagram_length;
    logic signed [63:0] incarnation_id;
    logic signed [63:0] sender_id;
    logic        [31:0] sequence_number;
    logic        [15:0] payload_length;
    logic        [7:0]  program_name_length;
    logic        [7:0]  node_name_length;

    modport source (
        output valid, datagram_length, incarnation_id, sender_id, sequence_number,
               payload_length, program_name_length, node_name_length,
        input  ready
    );
    modport sink (
        input  valid, datagram_length, incarnation_id, sender_id, sequence_number,
               payload_length, program_name_length, node_name_length,
        output ready
    );
endinterface

interface dfsm_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [2:0]  seq_status;
    logic [31:0] expected_seq;
    logic [31:0] previous_highest;

    modport source (
        output valid, verdict, seq_status, expected_seq, previous_highest,
        input  ready
    );
    modport sink (
        input  valid, verdict, seq_status, expected_seq, previous_highest,
        output ready
    );
endinterface

@@ design/dfsm_ctrl.sv @@
module dfsm_ctrl
    import dfsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.pass) begin
                    n_state = ST_DONE;
                end else if (i_sts.tbl_empty) begin
                    n_state = ST_MISS;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.match) begin
                    n_state = ST_HIT;
                end else if (i_sts.last) begin
                    n_state = ST_MISS;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_HIT: begin
                n_state = ST_DONE;
            end
            ST_MISS: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_space) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            ST_CMP: begin
                o_cmd.next_idx = !i_sts.match && !i_sts.last;
            end
            ST_HIT: begin
                o_cmd.hit = 1'b1;
            end
            ST_MISS: begin
                o_cmd.miss = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = i_sts.out_space;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ design/dfsm_dp.sv @@
module dfsm_dp
    import dfsm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dfsm_hdr_if.sink              i_hdr,
    dfsm_res_if.source            o_res,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts
);

    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic        r_inc_en;
    logic [63:0] r_inc_val;
    logic        r_snd_en;
    logic [63:0] r_snd_val;
    logic [7:0]  r_hdr_bytes;

    logic [15:0] r_len;
    logic [63:0] r_inc;
    logic [63:0] r_snd;
    logic [31:0] r_seq;
    logic [15:0] r_pay;
    logic [7:0]  r_pnl;
    logic [7:0]  r_nnl;

    logic [63:0] r_mem_sender  [TABLE_ENTRIES];
    logic [31:0] r_mem_highest [TABLE_ENTRIES];
    logic [63:0] r_rd_snd;
    logic [31:0] r_rd_hi;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;

    t_verdict    r_verdict;
    t_seq_status r_status;
    logic [31:0] r_exp;
    logic [31:0] r_prev;

    logic        r_out_valid;
    t_verdict    r_out_verdict;
    t_seq_status r_out_status;
    logic [31:0] r_out_exp;
    logic [31:0] r_out_prev;

    t_verdict    verdict;
    t_seq_status hit_status;
    logic [SUM_W-1:0] need_len;
    logic [31:0] hit_exp;
    logic        full;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_en    <= 1'b0;
            r_inc_val   <= '0;
            r_snd_en    <= 1'b0;
            r_snd_val   <= '0;
            r_hdr_bytes <= HDR_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INC_EN:    r_inc_en    <= i_cfg_data[0];
                CFG_INC_VAL:   r_inc_val   <= i_cfg_data;
                CFG_SND_EN:    r_snd_en    <= i_cfg_data[0];
                CFG_SND_VAL:   r_snd_val   <= i_cfg_data;
                CFG_HDR_BYTES: r_hdr_bytes <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_len <= i_hdr.datagram_length;
            r_inc <= i_hdr.incarnation_id;
            r_snd <= i_hdr.sender_id;
            r_seq <= i_hdr.sequence_number;
            r_pay <= i_hdr.payload_length;
            r_pnl <= i_hdr.program_name_length;
            r_nnl <= i_hdr.node_name_length;
        end
    end

    always_comb begin
        need_len = SUM_W'(r_hdr_bytes) + SUM_W'(r_pnl) + SUM_W'(r_nnl) + SUM_W'(r_pay);
        if (r_len < {8'd0, r_hdr_bytes}) begin
            verdict = VERDICT_SHORT;
        end else if (r_inc_en && (r_inc != r_inc_val)) begin
            verdict = VERDICT_INC_MISS;
        end else if (r_snd_en && (r_snd != r_snd_val)) begin
            verdict = VERDICT_SND_MISS;
        end else if (SUM_W'(r_len) < need_len) begin
            verdict = VERDICT_MALFORMED;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    always_comb begin
        hit_exp = r_rd_hi + 32'd1;
        if (r_rd_hi == 32'd0) begin
            hit_status = SEQ_FIRST_SEEN;
        end else if (r_seq == hit_exp) begin
            hit_status = SEQ_IN_ORDER;
        end else if (r_seq > hit_exp) begin
            hit_status = SEQ_MISSING;
        end else begin
            hit_status = SEQ_OUT_OF_ORDER;
        end
    end

    assign full    = (r_count == CW'(TABLE_ENTRIES));
    assign wr_en   = (i_cmd.hit && (r_seq > r_rd_hi)) || (i_cmd.miss && !full);
    assign wr_addr = i_cmd.hit ? r_idx[AW-1:0] : r_count[AW-1:0];
    assign wr_hi   = r_seq;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_highest[wr_addr] <= wr_hi;
        end
        if (i_cmd.miss && !full) begin
            r_mem_sender[wr_addr] <= r_snd;
        end
        if (i_cmd.rd) begin
            r_rd_snd <= r_mem_sender[r_idx[AW-1:0]];
            r_rd_hi  <= r_mem_highest[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.miss && !full) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_idx <= '0;
        end else if (i_cmd.next_idx) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_verdict <= verdict;
            r_status  <= SEQ_NOT_CHECKED;
            r_exp     <= '0;
            r_prev    <= '0;
        end else if (i_cmd.hit) begin
            r_status <= hit_status;
            r_exp    <= hit_exp;
            r_prev   <= r_rd_hi;
        end else if (i_cmd.miss) begin
            r_status <= full ? SEQ_TABLE_FULL : SEQ_FIRST_SEEN;
            r_exp    <= full ? 32'd0 : 32'd1;
            r_prev   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_verdict <= r_verdict;
            r_out_status  <= r_status;
            r_out_exp     <= r_exp;
            r_out_prev    <= r_prev;
        end
    end

    assign o_sts.pass      = (verdict == VERDICT_OK);
    assign o_sts.tbl_empty = (r_count == '0);
    assign o_sts.match     = (r_rd_snd == r_snd);
    assign o_sts.last      = ((r_idx + CW'(1)) == r_count);
    assign o_sts.out_space = !r_out_valid || o_res.ready;

    assign o_res.valid            = r_out_valid;
    assign o_res.verdict          = r_out_verdict;
    assign o_res.seq_status       = r_out_status;
    assign o_res.expected_seq     = r_out_exp;
    assign o_res.previous_highest = r_out_prev;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("table fill count exceeds the table size");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result is not presented");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_verdict != VERDICT_OK)) |->
            (r_out_status == SEQ_NOT_CHECKED && r_out_exp == '0 && r_out_prev == '0))
        else $error("dropped datagram carries sequence results");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == SEQ_TABLE_FULL)) |-> full)
        else $error("table full reported while entries remain free");

endmodule

@@ design/datagram_filter_sequence_monitor.sv @@
// Datagram filter and per-sender sequence monitor.
// Header fields of one received datagram arrive on the i_hdr channel; one result
// per datagram leaves on the o_res channel. A transaction moves on either channel
// at a rising clock edge where valid and ready are both high. Filter settings are
// written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must do so only
// while the block is idle, which the block does not enforce. A dropped datagram
// skips the table scan; its registered verdict moves to the output register once
// there is space. An accepted datagram reads and compares the sender table one
// entry at a time through a registered read port, at most the number of senders
// stored so far, at most TABLE_ENTRIES. The block is ready for a new datagram in
// the cycle after the previous result has moved into the output register, which
// happens when that register is empty or while its earlier result is being taken.
// If the receiver stalls, one finished result waits in the output register and
// the next datagram is still accepted and processed; it then waits for space.
// Synchronous reset empties the sender table (fill count to zero), drops any
// pending result and restores the default filter settings.
module datagram_filter_sequence_monitor
    import dfsm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dfsm_hdr_if.sink              i_hdr,
    dfsm_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dfsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_hdr.valid),
        .o_in_ready (i_hdr.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dfsm_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_hdr      (i_hdr),
        .o_res      (o_res),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule
